FILE: rtl/core/khe_pkg.sv
// ----------------------------------------------------------------------------
// khe_pkg
// Types, constants and the hex character function shared by the keypad
// scan and hex entry block.
// ----------------------------------------------------------------------------
package khe_pkg;

	localparam int RowW   = 4;
	localparam int ColW   = 2;
	localparam int KeyW   = RowW + ColW - 2;
	localparam int LastW  = 5;
	localparam int LimitW = 6;
	localparam int CharW  = 7;

	localparam logic [LastW-1:0]  NoKey      = 5'd31;
	localparam logic [LimitW-1:0] LimitReset = 6'd16;
	localparam logic [ColW-1:0]   LastCol    = 2'd3;
	localparam logic [CharW-1:0]  CharZero   = 7'h30;
	localparam logic [CharW-1:0]  CharA      = 7'h41;
	localparam logic [KeyW-1:0]   DecimalTop = 4'd9;

	typedef enum logic {
		CMD_SCAN  = 1'b0,
		CMD_CLEAR = 1'b1
	} cmd_t;

	typedef struct packed {
		logic            cmd;
		logic [RowW-1:0] row_sense;
	} item_t;

	typedef struct packed {
		logic [ColW-1:0]  next_column;
		logic             char_valid;
		logic [CharW-1:0] char_code;
		logic             clear_display;
	} result_t;

	// handshake state between the input register and the result register
	typedef struct packed {
		logic valid_s1;
		logic take_s1;
	} stage_ctl_t;

	function automatic logic [CharW-1:0] hex_char(input logic [KeyW-1:0] key);
		logic [CharW-1:0] k;
		k = {{(CharW-KeyW){1'b0}}, key};
		if (key > DecimalTop) begin
			return CharA + k - {{(CharW-KeyW){1'b0}}, DecimalTop} - 7'd1;
		end else begin
			return CharZero + k;
		end
	endfunction

endpackage

FILE: rtl/core/khe_if.sv
// ----------------------------------------------------------------------------
// khe_if
// Valid/ready channels for scan ticks in and characters out.
// ----------------------------------------------------------------------------
interface khe_in_if;
	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [khe_pkg::RowW-1:0] row_sense;

	modport source (output valid, output cmd, output row_sense, input ready);
	modport sink   (input valid, input cmd, input row_sense, output ready);
endinterface

interface khe_out_if;
	logic                      valid;
	logic                      ready;
	logic [khe_pkg::ColW-1:0]  next_column;
	logic                      char_valid;
	logic [khe_pkg::CharW-1:0] char_code;
	logic                      clear_display;

	modport source (output valid, output next_column, output char_valid,
		output char_code, output clear_display, input ready);
	modport sink   (input valid, input next_column, input char_valid,
		input char_code, input clear_display, output ready);
endinterface

FILE: rtl/core/keypad_scan_hex_entry_unit.sv
// ----------------------------------------------------------------------------
// keypad_scan_hex_entry_unit
// Scanner for a 4x4 key matrix that turns single key presses into hex
// ASCII characters, with a line limit and a clear command.
// ----------------------------------------------------------------------------
// Takes one transaction per clock cycle while the output is not stalled, and
// returns exactly one result transaction for each, held in the input register
// and then the result register. The key decode and the state update sit
// between those two registers, and the scan state moves only when a
// transaction passes into the result register. A clear command repeats the
// current column in next_column. The user must write line_limit through
// cfg_wr_en/cfg_wr_data only while no transaction is in flight (not enforced).
module keypad_scan_hex_entry_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [khe_pkg::LimitW-1:0] cfg_wr_data,
	khe_in_if.sink                     scan,
	khe_out_if.source                  chars
);

	khe_pkg::item_t      in_item;
	khe_pkg::item_t      item_s1;
	khe_pkg::stage_ctl_t ctl;
	khe_pkg::result_t    result;
	khe_pkg::result_t    result_s2;
	logic                up_ready;

	assign in_item.cmd       = scan.cmd;
	assign in_item.row_sense = scan.row_sense;

	khe_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (scan.valid),
		.in_ready   (scan.ready),
		.in_item    (in_item),
		.down_ready (up_ready),
		.ctl        (ctl),
		.item_s1    (item_s1)
	);

	khe_eval u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ctl         (ctl),
		.item_s1     (item_s1),
		.result      (result)
	);

	khe_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.result    (result),
		.up_ready  (up_ready),
		.out_valid (chars.valid),
		.out_ready (chars.ready),
		.result_s2 (result_s2)
	);

	assign chars.next_column   = result_s2.next_column;
	assign chars.char_valid    = result_s2.char_valid;
	assign chars.char_code     = result_s2.char_code;
	assign chars.clear_display = result_s2.clear_display;

endmodule

FILE: rtl/core/khe_in_reg.sv
// ----------------------------------------------------------------------------
// khe_in_reg
// Input register: holds one scan transaction until the evaluation stage
// passes it on to the result register.
// ----------------------------------------------------------------------------
module khe_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  khe_pkg::item_t      in_item,
	input  logic                down_ready,
	output khe_pkg::stage_ctl_t ctl,
	output khe_pkg::item_t      item_s1
);

	logic valid_s1;
	logic take_s1;

	assign take_s1  = valid_s1 && down_ready;
	assign in_ready = !valid_s1 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	assign ctl.valid_s1 = valid_s1;
	assign ctl.take_s1  = take_s1;

endmodule

FILE: rtl/core/khe_eval.sv
// ----------------------------------------------------------------------------
// khe_eval
// Scan state and key decode: finds a single pressed row, forms the key,
// applies the repeat and line limit rules and advances the column on scans.
// ----------------------------------------------------------------------------
module khe_eval (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [khe_pkg::LimitW-1:0]  cfg_wr_data,
	input  khe_pkg::stage_ctl_t         ctl,
	input  khe_pkg::item_t              item_s1,
	output khe_pkg::result_t            result
);

	logic [khe_pkg::LimitW-1:0] line_limit_q;
	logic [khe_pkg::ColW-1:0]   column_q;
	logic [khe_pkg::LastW-1:0]  last_key_q;
	logic                       seen_q;
	logic                       idle_q;
	logic [khe_pkg::LimitW-1:0] written_q;

	logic [khe_pkg::ColW-1:0]   column_d;
	logic [khe_pkg::LastW-1:0]  last_key_d;
	logic                       seen_d;
	logic                       idle_d;
	logic [khe_pkg::LimitW-1:0] written_d;

	logic [khe_pkg::RowW-1:0]   pressed;
	logic                       hit;
	logic [khe_pkg::ColW-1:0]   row_idx;
	logic [khe_pkg::KeyW-1:0]   key;
	logic                       emit;
	logic                       seen_now;

	assign pressed = ~item_s1.row_sense;

	always_comb begin
		hit     = 1'b1;
		row_idx = '0;
		case (pressed)
			4'b0001: row_idx = 2'd0;
			4'b0010: row_idx = 2'd1;
			4'b0100: row_idx = 2'd2;
			4'b1000: row_idx = 2'd3;
			default: hit = 1'b0;
		endcase
	end

	assign key  = {row_idx, column_q};
	assign emit = (item_s1.cmd == khe_pkg::CMD_SCAN) && hit && (written_q < line_limit_q)
		&& (({1'b0, key} != last_key_q) || idle_q);
	assign seen_now = seen_q || hit;

	always_comb begin
		column_d   = column_q;
		last_key_d = last_key_q;
		seen_d     = seen_q;
		idle_d     = idle_q;
		written_d  = written_q;
		if (item_s1.cmd == khe_pkg::CMD_CLEAR) begin
			written_d = '0;
		end else begin
			if (hit) begin
				last_key_d = {1'b0, key};
			end
			if (emit) begin
				written_d = written_q + 6'd1;
			end
			if (column_q == khe_pkg::LastCol) begin
				idle_d   = !seen_now;
				seen_d   = 1'b0;
				column_d = '0;
			end else begin
				seen_d   = seen_now;
				column_d = column_q + 2'd1;
			end
		end
	end

	always_comb begin
		result.next_column   = column_d;
		result.char_valid    = emit;
		result.char_code     = emit ? khe_pkg::hex_char(key) : '0;
		result.clear_display = (item_s1.cmd == khe_pkg::CMD_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= khe_pkg::LimitReset;
		end else if (cfg_wr_en) begin
			line_limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= '0;
			last_key_q <= khe_pkg::NoKey;
			seen_q     <= 1'b0;
			idle_q     <= 1'b1;
			written_q  <= '0;
		end else if (ctl.take_s1) begin
			column_q   <= column_d;
			last_key_q <= last_key_d;
			seen_q     <= seen_d;
			idle_q     <= idle_d;
			written_q  <= written_d;
		end
	end

endmodule

FILE: rtl/core/khe_out_reg.sv
// ----------------------------------------------------------------------------
// khe_out_reg
// Result register: holds one character transaction until the sink takes it.
// ----------------------------------------------------------------------------
module khe_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  khe_pkg::stage_ctl_t ctl,
	input  khe_pkg::result_t    result,
	output logic                up_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output khe_pkg::result_t    result_s2
);

	logic valid_s2;

	assign up_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= ctl.valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take_s1) begin
			result_s2 <= result;
		end
	end

endmodule
